FILE: design/buzzer_melody_sequencer_macros.svh
// Assertion macros for the buzzer melody sequencer checker.
// Needs aclk and aresetn in the scope of each use.
`ifndef BUZZER_MELODY_SEQUENCER_MACROS_SVH
`define BUZZER_MELODY_SEQUENCER_MACROS_SVH

// same-cycle implication
`define BMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bms check failed");

// next-cycle implication
`define BMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bms check failed");

`endif

FILE: design/bms_pkg.sv
// Package for the buzzer melody sequencer: field widths, command codes and
// note/frequency ROM functions. No dependencies.
`timescale 1ns / 1ps

package bms_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    localparam logic [7:0] CODE_SINGLE_MAX = 8'd21;
    localparam logic [7:0] CODE_SONG       = 8'd101;
    localparam logic [7:0] CODE_SCALE      = 8'd200;

    localparam logic [5:0] SONG_LEN  = 6'd32;
    localparam logic [5:0] SCALE_LEN = 6'd14;
    localparam logic [4:0] FREQ_LAST = 5'd20;
    localparam logic [7:0] SCALE_BEAT = 8'd4;

    // note frequency in Hz
    function automatic logic [9:0] freq_of(input logic [4:0] idx);
        logic [9:0] f;
        case (idx)
            5'd0:  f = 10'd262;
            5'd1:  f = 10'd294;
            5'd2:  f = 10'd330;
            5'd3:  f = 10'd350;
            5'd4:  f = 10'd393;
            5'd5:  f = 10'd441;
            5'd6:  f = 10'd495;
            5'd7:  f = 10'd131;
            5'd8:  f = 10'd147;
            5'd9:  f = 10'd165;
            5'd10: f = 10'd175;
            5'd11: f = 10'd196;
            5'd12: f = 10'd221;
            5'd13: f = 10'd248;
            5'd14: f = 10'd525;
            5'd15: f = 10'd589;
            5'd16: f = 10'd661;
            5'd17: f = 10'd700;
            5'd18: f = 10'd786;
            5'd19: f = 10'd882;
            default: f = 10'd990;
        endcase
        return f;
    endfunction

    // timer reload: floor(500000 / f) - 1 for a 1 MHz timer tick
    function automatic logic [15:0] reload_of(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'd0:  r = 16'd1907;
            5'd1:  r = 16'd1699;
            5'd2:  r = 16'd1514;
            5'd3:  r = 16'd1427;
            5'd4:  r = 16'd1271;
            5'd5:  r = 16'd1132;
            5'd6:  r = 16'd1009;
            5'd7:  r = 16'd3815;
            5'd8:  r = 16'd3400;
            5'd9:  r = 16'd3029;
            5'd10: r = 16'd2856;
            5'd11: r = 16'd2550;
            5'd12: r = 16'd2261;
            5'd13: r = 16'd2015;
            5'd14: r = 16'd951;
            5'd15: r = 16'd847;
            5'd16: r = 16'd755;
            5'd17: r = 16'd713;
            5'd18: r = 16'd635;
            5'd19: r = 16'd565;
            default: r = 16'd504;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] song_note(input logic [4:0] pos);
        logic [4:0] n;
        case (pos)
            5'd0, 5'd3, 5'd4, 5'd7, 5'd19, 5'd25, 5'd28, 5'd31: n = 5'd1;
            5'd1, 5'd5, 5'd26, 5'd29:                         n = 5'd2;
            5'd2, 5'd6, 5'd8, 5'd11, 5'd18, 5'd24:            n = 5'd3;
            5'd9, 5'd12, 5'd17, 5'd23:                        n = 5'd4;
            5'd15, 5'd21:                                     n = 5'd6;
            default:                                          n = 5'd5;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] song_beat(input logic [4:0] pos);
        logic [3:0] b;
        case (pos)
            5'd10, 5'd13, 5'd28, 5'd31:   b = 4'd8;
            5'd14, 5'd16, 5'd20, 5'd22:   b = 4'd3;
            5'd15, 5'd17, 5'd21, 5'd23:   b = 4'd1;
            default:                      b = 4'd4;
        endcase
        return b;
    endfunction

    // up the scale and back down
    function automatic logic [4:0] scale_note(input logic [3:0] pos);
        logic [4:0] n;
        if (pos < 4'd7) begin
            n = {1'b0, pos} + 5'd1;
        end else begin
            n = 5'd14 - {1'b0, pos};
        end
        return n;
    endfunction

endpackage

FILE: design/buzzer_melody_sequencer.sv
// Buzzer melody sequencer top level: input register, single-pass note
// sequencer update, result register. Uses bms_pkg.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser opcode; tdata code, beat, repeat
//  m_      | out | m_tvalid/m_tready  | tdata pin, reload, write, playing, taken
//
// One word in, one word out. A word passes the input register, then the result register,
// before m_tvalid rises; one word per cycle is sustained while m_tready stays high.
// The sequencer state updates as a word moves from the input to the result register.
// Reset (aresetn low, synchronous) leaves the block idle with the pin low.
// A stalled m_ side holds both registers; s_tready drops only when both are full.

module buzzer_melody_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bms_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] note_code, [15:8] beat_length,
                                                     // [23:16] repeat_count
    input  logic                          s_tuser,   // [0] opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bms_pkg::OUT_DATA_W-1:0] m_tdata   // [0] pin_level, [16:1] reload_value,
                                                     // [17] reload_write, [18] playing,
                                                     // [19] command_taken, [23:20] zero
);

    typedef enum logic [1:0] {
        SRC_SINGLE = 2'd0,
        SRC_SONG   = 2'd1,
        SRC_SCALE  = 2'd2
    } src_t;

    // input register
    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [bms_pkg::IN_DATA_W-1:0] in_data_reg;

    // result register
    logic                           out_valid_reg;
    logic [bms_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    // sequencer state
    logic [7:0]  passes_reg, passes_next;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] note_ticks_reg, note_ticks_next;
    logic [15:0] sound_ticks_reg, sound_ticks_next;
    logic        gate_reg, gate_next;
    logic        pin_reg, pin_next;
    src_t        src_reg, src_next;
    logic [4:0]  single_note_reg, single_note_next;
    logic [7:0]  single_beat_reg, single_beat_next;

    logic        out_free;
    logic        advance;
    logic [7:0]  cmd_code, cmd_beat, cmd_rep;
    logic        cmd_ok;
    logic [4:0]  fetch_code;
    logic [7:0]  fetch_beat;
    logic [4:0]  freq_idx;
    logic [9:0]  freq;
    logic [17:0] note_prod;
    logic [15:0] note_len;
    logic [15:0] tick_inc;
    logic [5:0]  src_len;
    logic [15:0] reload;
    logic        reload_wr;
    logic        taken;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cmd_code = in_data_reg[7:0];
    assign cmd_beat = in_data_reg[15:8];
    assign cmd_rep  = in_data_reg[23:16];

    // note fetch for the current position
    always_comb begin
        case (src_reg)
            SRC_SONG: begin
                fetch_code = bms_pkg::song_note(pos_reg < bms_pkg::SONG_LEN ? pos_reg[4:0] : 5'd0);
                fetch_beat = {4'd0, bms_pkg::song_beat(
                                  pos_reg < bms_pkg::SONG_LEN ? pos_reg[4:0] : 5'd0)};
                src_len    = bms_pkg::SONG_LEN;
            end
            SRC_SCALE: begin
                fetch_code = bms_pkg::scale_note(
                                 pos_reg < bms_pkg::SCALE_LEN ? pos_reg[3:0] : 4'd0);
                fetch_beat = bms_pkg::SCALE_BEAT;
                src_len    = bms_pkg::SCALE_LEN;
            end
            default: begin
                fetch_code = single_note_reg;
                fetch_beat = single_beat_reg;
                src_len    = 6'd1;
            end
        endcase
    end

    always_comb begin
        if (fetch_code == 5'd0) begin
            freq_idx = 5'd0;
        end else if (fetch_code - 5'd1 > bms_pkg::FREQ_LAST) begin
            freq_idx = bms_pkg::FREQ_LAST;
        end else begin
            freq_idx = fetch_code - 5'd1;
        end
    end

    assign freq      = bms_pkg::freq_of(freq_idx);
    assign note_prod = {10'd0, fetch_beat} * {8'd0, freq};
    assign note_len  = note_prod[17:2];
    assign tick_inc  = tick_reg + 16'd1;

    always_comb begin
        passes_next      = passes_reg;
        pos_next         = pos_reg;
        tick_next        = tick_reg;
        note_ticks_next  = note_ticks_reg;
        sound_ticks_next = sound_ticks_reg;
        gate_next        = gate_reg;
        pin_next         = pin_reg;
        src_next         = src_reg;
        single_note_next = single_note_reg;
        single_beat_next = single_beat_reg;
        reload           = 16'd0;
        reload_wr        = 1'b0;
        taken            = 1'b0;
        cmd_ok           = 1'b0;

        if (in_op_reg == bms_pkg::OP_PLAY) begin
            if (cmd_code >= 8'd1 && cmd_code <= bms_pkg::CODE_SINGLE_MAX) begin
                cmd_ok           = 1'b1;
                src_next         = SRC_SINGLE;
                single_note_next = cmd_code[4:0];
                single_beat_next = cmd_beat;
            end else if (cmd_code == bms_pkg::CODE_SONG) begin
                cmd_ok   = 1'b1;
                src_next = SRC_SONG;
            end else if (cmd_code == bms_pkg::CODE_SCALE) begin
                cmd_ok   = 1'b1;
                src_next = SRC_SCALE;
            end
            if (cmd_ok) begin
                passes_next = (cmd_rep == 8'd0) ? 8'd1 : cmd_rep;
                pos_next    = 6'd0;
                tick_next   = 16'd0;
                gate_next   = 1'b1;
                taken       = 1'b1;
            end
        end else if (passes_reg != 8'd0) begin
            pin_next = gate_reg ? !pin_reg : 1'b0;
            if (tick_reg == 16'd0) begin
                // note start
                reload           = bms_pkg::reload_of(freq_idx);
                reload_wr        = 1'b1;
                note_ticks_next  = note_len;
                sound_ticks_next = note_len - {2'd0, note_len[15:2]};
                gate_next        = 1'b1;
                tick_next        = 16'd1;
            end else if (tick_reg >= note_ticks_reg) begin
                tick_next = 16'd0;
                pos_next  = pos_reg + 6'd1;
            end else begin
                tick_next = tick_inc;
                if (tick_inc == sound_ticks_reg) begin
                    gate_next = 1'b0;
                end
            end
            // end of pass
            if (pos_next >= src_len) begin
                pos_next    = 6'd0;
                passes_next = passes_reg - 8'd1;
            end
            if (passes_next == 8'd0) begin
                pin_next = 1'b0;
            end
        end

        out_data_next = {4'd0, taken, (passes_next != 8'd0), reload_wr, reload, pin_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            passes_reg      <= 8'd0;
            pos_reg         <= 6'd0;
            tick_reg        <= 16'd0;
            note_ticks_reg  <= 16'd0;
            sound_ticks_reg <= 16'd0;
            gate_reg        <= 1'b1;
            pin_reg         <= 1'b0;
            src_reg         <= SRC_SINGLE;
            single_note_reg <= 5'd0;
            single_beat_reg <= 8'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_op_reg    <= s_tuser;
                in_data_reg  <= s_tdata;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg   <= 1'b1;
                out_data_reg    <= out_data_next;
                passes_reg      <= passes_next;
                pos_reg         <= pos_next;
                tick_reg        <= tick_next;
                note_ticks_reg  <= note_ticks_next;
                sound_ticks_reg <= sound_ticks_next;
                gate_reg        <= gate_next;
                pin_reg         <= pin_next;
                src_reg         <= src_next;
                single_note_reg <= single_note_next;
                single_beat_reg <= single_beat_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: design/bms_checker.sv
// Port-level checker for buzzer_melody_sequencer, bound to the top level.
// Uses bms_pkg widths and the macros header.
`timescale 1ns / 1ps
`include "buzzer_melody_sequencer_macros.svh"

module bms_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bms_pkg::OUT_DATA_W-1:0] m_tdata
);

    // stalled result word holds
    `BMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // pin is low whenever nothing is playing
    `BMS_ASSERT_NOW(a_idle_pin_low, m_tvalid && !m_tdata[18], !m_tdata[0])
    // a note start only happens mid-play and never on a command word
    `BMS_ASSERT_NOW(a_reload_ctx, m_tvalid && m_tdata[17], m_tdata[18] && !m_tdata[19])
    // an accepted command always starts playback
    `BMS_ASSERT_NOW(a_cmd_plays, m_tvalid && m_tdata[19], m_tdata[18] && !m_tdata[17])
    // reload is zero unless written, else within the ROM range
    `BMS_ASSERT_NOW(a_reload_range, m_tvalid,
                    m_tdata[17] ? (m_tdata[16:1] >= 16'd504 && m_tdata[16:1] <= 16'd3815)
                                : (m_tdata[16:1] == 16'd0))

endmodule

bind buzzer_melody_sequencer bms_checker u_bms_checker (.*);
